### src/qvr_pkg.sv
// Shared constants for the quaternion vector rotation block.
package qvr_pkg;

	// Default geometry, handed down as top-level parameter defaults
	localparam int VEC_WIDTH_DEF = 24;
	localparam int QUAT_FRAC_DEF = 14;

	// Quaternion register format: signed Q1.x in 16 bits
	localparam int QUAT_W  = 16;
	localparam int QPROD_W = 2 * QUAT_W;   // one quaternion product
	localparam int QSUM_W  = QPROD_W + 2;  // sum of four products, or doubled sum of two

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = 2'd3;

	// Identity quaternion scalar part after reset
	localparam logic signed [QUAT_W-1:0] QUAT_W_RESET = 16'sd16384;

	// Cycles from a quaternion register update to a valid coefficient matrix
	localparam int                 SETTLE_W      = 2;
	localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

endpackage

### src/qvr_coef.sv
// Quaternion registers and the three-stage rotation matrix generator.
module qvr_coef #(
	parameter int QUAT_FRAC = qvr_pkg::QUAT_FRAC_DEF,
	parameter int COEF_W    = QUAT_FRAC + 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [qvr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [qvr_pkg::QUAT_W-1:0]    cfg_data,
	output logic [2:0][2:0][COEF_W-1:0]   coef
);
	import qvr_pkg::*;

	localparam logic signed [QSUM_W-1:0] HALF    = QSUM_W'(1) << (QUAT_FRAC - 1);
	localparam logic signed [QSUM_W-1:0] CLIM_HI = (QSUM_W'(1) << (QUAT_FRAC + 3)) - 1;
	localparam logic signed [QSUM_W-1:0] CLIM_LO = -(QSUM_W'(1) << (QUAT_FRAC + 3));

	logic signed [QUAT_W-1:0]  quat_x_q, quat_y_q, quat_z_q, quat_w_q;
	logic signed [QPROD_W-1:0] xx_s1, yy_s1, zz_s1, ww_s1, xy_s1;
	logic signed [QPROD_W-1:0] yz_s1, zw_s1, wx_s1, xz_s1, yw_s1;
	logic signed [QSUM_W-1:0]  sum_s2 [3][3];
	logic [2:0][2:0][COEF_W-1:0] coef_s3;

	// Round to nearest, ties up, then clip to signed Q3
	function automatic logic [COEF_W-1:0] coef_round(input logic signed [QSUM_W-1:0] e);
		logic signed [QSUM_W-1:0] sh;
		logic signed [QSUM_W-1:0] cl;
		sh = (e + HALF) >>> QUAT_FRAC;
		if (sh < CLIM_LO) begin
			cl = CLIM_LO;
		end else if (sh > CLIM_HI) begin
			cl = CLIM_HI;
		end else begin
			cl = sh;
		end
		return cl[COEF_W-1:0];
	endfunction

	function automatic logic signed [QSUM_W-1:0] ext(input logic signed [QPROD_W-1:0] p);
		return QSUM_W'(p);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_x_q <= '0;
			quat_y_q <= '0;
			quat_z_q <= '0;
			quat_w_q <= QUAT_W_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_QUAT_X: quat_x_q <= cfg_data;
				REG_QUAT_Y: quat_y_q <= cfg_data;
				REG_QUAT_Z: quat_z_q <= cfg_data;
				REG_QUAT_W: quat_w_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pairwise products
	always_ff @(posedge clk) begin
		xx_s1 <= quat_x_q * quat_x_q;
		yy_s1 <= quat_y_q * quat_y_q;
		zz_s1 <= quat_z_q * quat_z_q;
		ww_s1 <= quat_w_q * quat_w_q;
		xy_s1 <= quat_x_q * quat_y_q;
		yz_s1 <= quat_y_q * quat_z_q;
		zw_s1 <= quat_z_q * quat_w_q;
		wx_s1 <= quat_w_q * quat_x_q;
		xz_s1 <= quat_x_q * quat_z_q;
		yw_s1 <= quat_y_q * quat_w_q;
	end

	// Exact coefficients in Q.(2*frac)
	always_ff @(posedge clk) begin
		sum_s2[0][0] <= ext(xx_s1) - ext(yy_s1) - ext(zz_s1) + ext(ww_s1);
		sum_s2[0][1] <= (ext(xy_s1) - ext(zw_s1)) <<< 1;
		sum_s2[0][2] <= (ext(yw_s1) + ext(xz_s1)) <<< 1;
		sum_s2[1][0] <= (ext(zw_s1) + ext(xy_s1)) <<< 1;
		sum_s2[1][1] <= ext(yy_s1) - ext(xx_s1) - ext(zz_s1) + ext(ww_s1);
		sum_s2[1][2] <= (ext(yz_s1) - ext(wx_s1)) <<< 1;
		sum_s2[2][0] <= (ext(xz_s1) - ext(yw_s1)) <<< 1;
		sum_s2[2][1] <= (ext(yz_s1) + ext(wx_s1)) <<< 1;
		sum_s2[2][2] <= ext(zz_s1) - ext(xx_s1) - ext(yy_s1) + ext(ww_s1);
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				coef_s3[r][c] <= coef_round(sum_s2[r][c]);
			end
		end
	end

	assign coef = coef_s3;

endmodule

### src/quaternion_vector_rotate_top.sv
// Top level of the quaternion vector rotation block.
//
// Rotates a stream of 3D vectors by the quaternion in four registers.
// Write quat_x, quat_y, quat_z, quat_w (indexes 0..3, signed Q1.frac) through
// cfg_we/cfg_idx/cfg_data while the stream is idle. A write rebuilds the
// 3x3 rotation matrix through the product, sum and rounding registers;
// s_tready stays low during the write and while the matrix settles, and
// after reset while the matrix flushes out of the identity registers.
// Input beats carry vec_x, vec_y, vec_z on s_tdata; output beats carry
// rot_x, rot_y, rot_z on m_tdata and the clip flag on m_tuser.
// An accepted input beat reaches m_tvalid through the product, row sum and
// round-and-saturate registers. Throughput: one vector per clock while the
// receiver is ready and the matrix has settled, set by the nine parallel
// coefficient-by-component multipliers. When the receiver stalls, each full
// stage holds its beat while an empty stage still takes one, so
// bubbles are filled before s_tready drops; nothing is dropped or repeated.
// Reset (arst_n low) empties the pipeline and restores the identity.
module quaternion_vector_rotate_top #(
	parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF,
	parameter int QUAT_FRAC = qvr_pkg::QUAT_FRAC_DEF,
	parameter int DATA_W    = ((3 * VEC_WIDTH + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [qvr_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [qvr_pkg::QUAT_W-1:0]    cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [DATA_W-1:0]             s_tdata,   // vec_x, vec_y, vec_z, zero pad
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [DATA_W-1:0]             m_tdata,   // rot_x, rot_y, rot_z, zero pad
	output logic                          m_tuser    // saturated
);
	import qvr_pkg::*;

	localparam int COEF_W = QUAT_FRAC + 4;
	localparam int PROD_W = COEF_W + VEC_WIDTH;
	localparam int ACC_W  = PROD_W + 2;

	localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (QUAT_FRAC - 1);
	localparam logic signed [ACC_W-1:0] VLIM_HI = (ACC_W'(1) << (VEC_WIDTH - 1)) - 1;
	localparam logic signed [ACC_W-1:0] VLIM_LO = -(ACC_W'(1) << (VEC_WIDTH - 1));

	logic [2:0][2:0][COEF_W-1:0] coef;
	logic [SETTLE_W-1:0]         settle_q;
	logic                        en_s1, en_s2, en_s3;
	logic                        accept;
	logic                        valid_s1, valid_s2, valid_s3;
	logic signed [VEC_WIDTH-1:0] vec [3];
	logic signed [PROD_W-1:0]    prod_s1 [3][3];
	logic signed [ACC_W-1:0]     acc_s2 [3];
	logic signed [VEC_WIDTH-1:0] rot_s3 [3];
	logic                        sat_s3;
	logic signed [VEC_WIDTH-1:0] rot_n [3];
	logic [2:0]                  clip_n;

	qvr_coef #(
		.QUAT_FRAC (QUAT_FRAC),
		.COEF_W    (COEF_W)
	) u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.coef     (coef)
	);

	// Hold off input until the matrix reflects the latest registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_CYCLES;
		end else if (cfg_we) begin
			settle_q <= SETTLE_CYCLES;
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	// A stage advances when it is empty or the stage after it advances
	assign en_s3    = !valid_s3 || m_tready;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign s_tready = en_s1 && (settle_q == '0) && !cfg_we;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= accept;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			vec[c] = s_tdata[c*VEC_WIDTH +: VEC_WIDTH];
		end
	end

	// Stage 1: nine coefficient-by-component products
	always_ff @(posedge clk) begin
		if (en_s1 && accept) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= $signed(coef[r][c]) * vec[c];
				end
			end
		end
	end

	// Stage 2: row sums, rounding offset folded in
	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			for (int r = 0; r < 3; r++) begin
				acc_s2[r] <= ACC_W'(prod_s1[r][0]) + ACC_W'(prod_s1[r][1])
				           + ACC_W'(prod_s1[r][2]) + HALF;
			end
		end
	end

	// Stage 3: drop fraction bits and saturate to the vector width
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			logic signed [ACC_W-1:0] sh;
			sh = acc_s2[r] >>> QUAT_FRAC;
			if (sh < VLIM_LO) begin
				rot_n[r]  = VLIM_LO[VEC_WIDTH-1:0];
				clip_n[r] = 1'b1;
			end else if (sh > VLIM_HI) begin
				rot_n[r]  = VLIM_HI[VEC_WIDTH-1:0];
				clip_n[r] = 1'b1;
			end else begin
				rot_n[r]  = sh[VEC_WIDTH-1:0];
				clip_n[r] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			for (int r = 0; r < 3; r++) begin
				rot_s3[r] <= rot_n[r];
			end
			sat_s3 <= |clip_n;
		end
	end

	assign m_tvalid = valid_s3;
	assign m_tdata  = DATA_W'({rot_s3[2], rot_s3[1], rot_s3[0]});
	assign m_tuser  = sat_s3;

endmodule

### tb/tb.sv
// Self-checking testbench for the quaternion vector rotation block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qvr_pkg::*;

	localparam int VW = VEC_WIDTH_DEF;
	localparam int QF = QUAT_FRAC_DEF;
	localparam int DW = ((3 * VW + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_REPORTS = 60;

	localparam logic signed [VW-1:0] VEC_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VEC_MIN = {1'b1, {(VW-1){1'b0}}};
	localparam logic signed [QUAT_W-1:0] Q_MAX = 16'sh7fff;
	localparam logic signed [QUAT_W-1:0] Q_MIN = 16'sh8000;

	typedef struct {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] z;
	} vec_t;

	typedef struct {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] z;
		logic                 sat;
	} rot_t;

	typedef enum int {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN, RDY_LONG_STALL} ready_mode_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx  = REG_QUAT_X;
	logic [QUAT_W-1:0]    cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [DW-1:0]        s_tdata  = '0;   // vec_x, vec_y, vec_z, zero pad
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [DW-1:0]        m_tdata;         // rot_x, rot_y, rot_z, zero pad
	logic                 m_tuser;         // saturated

	// Shadow copy of the quaternion registers, indexed by register index
	logic signed [QUAT_W-1:0] quat_cfg [4];

	vec_t vec_pending_q [$];   // vectors waiting to be driven
	rot_t rot_expect_q  [$];   // predicted rotations, oldest first

	int   fault_count = 0;
	int   cycle_count = 0;
	logic in_taken    = 1'b0;
	int   burst_left  = 1;
	int   gap_left    = 0;
	vec_t nxt_vec;
	rot_t want_rot;

	ready_mode_t      rdy_mode    = RDY_ALWAYS;
	int               rdy_count   = 0;
	int               stall_left  = 0;
	logic [15:0]      rdy_pattern = 16'hffff;

	quaternion_vector_rotate_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Rotation predictor
	// ------------------------------------------------------------------

	// Round to nearest, ties toward +inf, dropping QF fraction bits
	function automatic longint round_frac(input longint a);
		return (a + (longint'(1) <<< (QF - 1))) >>> QF;
	endfunction

	// Matrix coefficient: round to Q3.QF and clip quietly
	function automatic longint quant_coef(input longint exact);
		longint c;
		longint lim;
		c   = round_frac(exact);
		lim = longint'(1) <<< (QF + 3);
		if (c < -lim)
			c = -lim;
		else if (c > lim - 1)
			c = lim - 1;
		return c;
	endfunction

	function automatic rot_t rotate_by_quat(input vec_t v);
		longint qx, qy, qz, qw;
		longint xx, yy, zz, ww, xy, yz, zw, wx, xz, yw;
		longint m [3][3];
		longint vin [3];
		longint acc, o, lim;
		logic signed [VW-1:0] res [3];
		rot_t r;
		qx = longint'(quat_cfg[REG_QUAT_X]);
		qy = longint'(quat_cfg[REG_QUAT_Y]);
		qz = longint'(quat_cfg[REG_QUAT_Z]);
		qw = longint'(quat_cfg[REG_QUAT_W]);
		xx = qx * qx; yy = qy * qy; zz = qz * qz; ww = qw * qw;
		xy = qx * qy; yz = qy * qz; zw = qz * qw;
		wx = qw * qx; xz = qx * qz; yw = qy * qw;
		// Sandwich product q v q* written out as a matrix, unnormalized
		m[0][0] = quant_coef(xx - yy - zz + ww);
		m[0][1] = quant_coef(2 * (xy - zw));
		m[0][2] = quant_coef(2 * (xz + yw));
		m[1][0] = quant_coef(2 * (xy + zw));
		m[1][1] = quant_coef(-xx + yy - zz + ww);
		m[1][2] = quant_coef(2 * (yz - wx));
		m[2][0] = quant_coef(2 * (xz - yw));
		m[2][1] = quant_coef(2 * (yz + wx));
		m[2][2] = quant_coef(-xx - yy + zz + ww);
		vin[0] = longint'(v.x);
		vin[1] = longint'(v.y);
		vin[2] = longint'(v.z);
		lim    = longint'(1) <<< (VW - 1);
		r.sat  = 1'b0;
		for (int row = 0; row < 3; row++) begin
			acc = m[row][0] * vin[0] + m[row][1] * vin[1] + m[row][2] * vin[2];
			o   = round_frac(acc);
			if (o < -lim) begin
				o = -lim;
				r.sat = 1'b1;
			end else if (o > lim - 1) begin
				o = lim - 1;
				r.sat = 1'b1;
			end
			res[row] = o[VW-1:0];
		end
		r.x = res[0];
		r.y = res[1];
		r.z = res[2];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic signed [VW-1:0] corner_value();
		case ($urandom_range(0, 4))
			0:       return VEC_MAX;
			1:       return VEC_MIN;
			2:       return '0;
			3:       return '1;
			default: return VW'(1);
		endcase
	endfunction

	function automatic logic signed [VW-1:0] pick_component(input int kind);
		if (kind < 12)
			return VW'($urandom());
		else if (kind < 17)
			return VW'(int'($urandom_range(0, 8192)) - 4096);
		return corner_value();
	endfunction

	// Mostly full-range vectors, some small ones, some at the corners
	function automatic vec_t rand_vec();
		vec_t v;
		int   kind;
		kind = $urandom_range(0, 19);
		v.x  = pick_component(kind);
		v.y  = pick_component(kind);
		v.z  = pick_component(kind);
		return v;
	endfunction

	function automatic vec_t mk_vec(input logic signed [VW-1:0] x, y, z);
		vec_t v;
		v.x = x;
		v.y = y;
		v.z = z;
		return v;
	endfunction

	// Write one quaternion register; the stream is idle whenever this runs
	task automatic write_quat(input logic [CFG_IDX_W-1:0] idx,
	                          input logic signed [QUAT_W-1:0] val);
		@(negedge clk);
		cfg_we        <= 1'b1;
		cfg_idx       <= idx;
		cfg_data      <= val;
		quat_cfg[idx]  = val;
	endtask

	task automatic load_quat(input logic signed [QUAT_W-1:0] qx, qy, qz, qw);
		write_quat(REG_QUAT_X, qx);
		write_quat(REG_QUAT_Y, qy);
		write_quat(REG_QUAT_Z, qz);
		write_quat(REG_QUAT_W, qw);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every queued vector is accepted and every rotation checked,
	// then let the pipeline latency run out; poll at the rising edge, where
	// s_tvalid and both queues have settled
	task automatic drain_stream();
		while (vec_pending_q.size() != 0 || s_tvalid || rot_expect_q.size() != 0)
			@(posedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic random_phase(input logic signed [QUAT_W-1:0] qx, qy, qz, qw,
	                            input int count);
		load_quat(qx, qy, qz, qw);
		for (int i = 0; i < count; i++)
			vec_pending_q.push_back(rand_vec());
		drain_stream();
	endtask

	task automatic check_field(input string fname, input longint want, input longint got);
		if (want != got) begin
			fault_count++;
			if (fault_count <= MAX_REPORTS)
				$display("%0t ns: %s expected %0d actual %0d", $time, fname, want, got);
		end
	endtask

	// ------------------------------------------------------------------
	// Sender: bursts of random length, random gaps in between
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		// Advance only once the current beat is gone or nothing is offered
		if (!s_tvalid || in_taken) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (vec_pending_q.size() > 0) begin
				nxt_vec = vec_pending_q.pop_front();
				s_tdata  <= DW'({nxt_vec.z, nxt_vec.y, nxt_vec.x});
				s_tvalid <= 1'b1;
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					// Now and then a long burst, to keep stretches with no gaps
					burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
					                                          : $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: tready pattern switches mode whenever its mode counter runs out
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (rdy_count == 0) begin
			rdy_mode    <= ready_mode_t'($urandom_range(0, 3));
			rdy_pattern <= 16'($urandom());
			rdy_count   <= $urandom_range(50, 300);
		end else begin
			rdy_count <= rdy_count - 1;
		end
		case (rdy_mode)
			RDY_ALWAYS:  m_tready <= 1'b1;
			RDY_RANDOM:  m_tready <= ($urandom_range(0, 99) < 70);
			RDY_PATTERN: m_tready <= rdy_pattern[rdy_count % 16];
			default: begin
				// Mostly ready, with occasional long holds
				if (stall_left > 0) begin
					stall_left <= stall_left - 1;
					m_tready   <= 1'b0;
				end else if ($urandom_range(0, 15) == 0) begin
					stall_left <= $urandom_range(4, 24);
					m_tready   <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Monitors: predict on each input beat, check each output beat
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		in_taken <= s_tvalid && s_tready;
		if (m_tvalid && m_tready) begin
			if (rot_expect_q.size() == 0) begin
				fault_count++;
				if (fault_count <= MAX_REPORTS)
					$display("%0t ns: output beat with none expected, actual x %0d y %0d z %0d",
					         $time, $signed(m_tdata[VW-1:0]), $signed(m_tdata[2*VW-1:VW]),
					         $signed(m_tdata[3*VW-1:2*VW]));
			end else begin
				want_rot = rot_expect_q.pop_front();
				check_field("rot_x", want_rot.x, $signed(m_tdata[VW-1:0]));
				check_field("rot_y", want_rot.y, $signed(m_tdata[2*VW-1:VW]));
				check_field("rot_z", want_rot.z, $signed(m_tdata[3*VW-1:2*VW]));
				check_field("saturated", want_rot.sat, m_tuser);
			end
		end
		// Input beat: predict with the quaternion in force now
		if (s_tvalid && s_tready)
			rot_expect_q.push_back(rotate_by_quat(mk_vec(s_tdata[VW-1:0],
			                                             s_tdata[2*VW-1:VW],
			                                             s_tdata[3*VW-1:2*VW])));
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("quaternion_vector_rotate_top: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		quat_cfg[REG_QUAT_X] = '0;
		quat_cfg[REG_QUAT_Y] = '0;
		quat_cfg[REG_QUAT_Z] = '0;
		quat_cfg[REG_QUAT_W] = QUAT_W_RESET;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Identity straight out of reset, no writes: field extremes pass through
		vec_pending_q.push_back(mk_vec('0, '0, '0));
		vec_pending_q.push_back(mk_vec(VEC_MAX, VEC_MAX, VEC_MAX));
		vec_pending_q.push_back(mk_vec(VEC_MIN, VEC_MIN, VEC_MIN));
		vec_pending_q.push_back(mk_vec(VEC_MAX, VEC_MIN, '0));
		vec_pending_q.push_back(mk_vec('0, VEC_MAX, VEC_MIN));
		vec_pending_q.push_back(mk_vec(VEC_MIN, '0, VEC_MAX));
		vec_pending_q.push_back(mk_vec('1, VW'(1), '1));
		vec_pending_q.push_back(mk_vec(24'haaaaaa, 24'h555555, 24'haaaaaa));
		vec_pending_q.push_back(mk_vec(24'h555555, 24'haaaaaa, 24'h555555));
		drain_stream();

		// Most negative quaternion: three off-diagonal coefficients clip to Q3 bounds, the rest are zero
		load_quat(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		vec_pending_q.push_back(mk_vec(VEC_MAX, VEC_MAX, VEC_MAX));
		vec_pending_q.push_back(mk_vec(VW'(1), VW'(1), VW'(1)));
		vec_pending_q.push_back(mk_vec(VEC_MIN, '0, '0));
		drain_stream();

		// Unnormalized quaternion of norm 2: result scaled by four
		load_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
		vec_pending_q.push_back(mk_vec(VEC_MAX, '0, '0));
		vec_pending_q.push_back(mk_vec('0, VEC_MIN, '0));
		vec_pending_q.push_back(mk_vec(VW'(100), -VW'(200), VW'(300)));
		drain_stream();

		// Most positive quaternion
		load_quat(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		vec_pending_q.push_back(mk_vec(VEC_MIN, VEC_MAX, VEC_MIN));
		vec_pending_q.push_back(mk_vec(VW'(3), -VW'(5), VW'(7)));
		vec_pending_q.push_back(mk_vec('0, '0, VEC_MAX));
		drain_stream();

		// Random part: each phase loads a new quaternion and streams vectors
		for (int p = 0; p < 12; p++) begin
			case (p % 4)
				0: random_phase(16'($urandom()), 16'($urandom()), 16'($urandom()),
				                16'($urandom()), 120);
				1: random_phase(16'(int'($urandom_range(0, 32768)) - 16384),
				                16'(int'($urandom_range(0, 32768)) - 16384),
				                16'(int'($urandom_range(0, 32768)) - 16384),
				                16'(int'($urandom_range(0, 32768)) - 16384), 120);
				2: begin
					// Quarter turn about one axis, either sense
					case ($urandom_range(0, 2))
						0: random_phase(($urandom_range(0, 1) != 0) ? 16'sd11585 : -16'sd11585,
						                '0, '0, 16'sd11585, 120);
						1: random_phase('0, ($urandom_range(0, 1) != 0) ? 16'sd11585 : -16'sd11585,
						                '0, 16'sd11585, 120);
						default: random_phase('0, '0,
						                ($urandom_range(0, 1) != 0) ? 16'sd11585 : -16'sd11585,
						                16'sd11585, 120);
					endcase
				end
				default: random_phase(16'(int'($urandom_range(0, 16384)) - 8192),
				                      16'(int'($urandom_range(0, 16384)) - 8192),
				                      16'(int'($urandom_range(0, 16384)) - 8192),
				                      16'(int'($urandom_range(0, 16384)) - 8192), 120);
			endcase
		end

		// Register extremes mixed, then the zero quaternion, then back to identity
		random_phase(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 40);
		random_phase('0, '0, '0, '0, 20);
		random_phase('0, '0, '0, QUAT_W_RESET, 20);

		drain_stream();
		if (fault_count == 0)
			$display("quaternion_vector_rotate_top: match");
		else
			$display("quaternion_vector_rotate_top: mismatch");
		$finish;
	end

endmodule

### sim.f
src/qvr_pkg.sv
src/qvr_coef.sv
src/quaternion_vector_rotate_top.sv
tb/tb.sv
